>>> rtl/mvr_pkg.sv
// Shared types and constants for the motion vector reconstruction block.
package mvr_pkg;

    localparam int MV_BASE_RANGE = 16;
    localparam int MV_MAX_R      = 8;

    localparam int RANGE_W  = 4;   // residual size register width
    localparam int CODE_W   = 6;   // motion code width
    localparam int RESID_W  = 8;   // residual width
    localparam int PRED_W   = 14;  // stored predictor width
    localparam int MVH_W    = 13;  // horizontal output width
    localparam int MVV_W    = 14;  // vertical output width
    localparam int CALC_W   = 16;  // working width of the update arithmetic
    localparam int ROW_W    = 2;   // {direction, slot}
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_H = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_V = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BWD_H = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BWD_V = 2'd3;

    // Request types
    localparam logic REQ_DECODE = 1'b0;
    localparam logic REQ_RESET  = 1'b1;

    // Predictor write request from the datapath to the predictor store
    typedef struct packed {
        logic                     clear;
        logic                     we;
        logic                     dir;
        logic                     slot;
        logic                     share;
        logic signed [PRED_W-1:0] h;
        logic signed [PRED_W-1:0] v;
    } t_pred_wr;

endpackage

>>> rtl/mvr_rebuild.sv
// One vector component update: apply code and residual to a predictor and wrap.
module mvr_rebuild import mvr_pkg::*; (
    input  logic signed [PRED_W-1:0]  i_pred,
    input  logic        [RANGE_W-1:0] i_range,
    input  logic signed [CODE_W-1:0]  i_code,
    input  logic        [RESID_W-1:0] i_resid,
    output logic signed [CALC_W-1:0]  o_result
);

    logic        [RANGE_W-1:0] w_r;
    logic signed [CALC_W-1:0]  w_lim;
    logic        [CODE_W-1:0]  w_mag;
    logic        [CODE_W-1:0]  w_mag_m1;
    logic        [CALC_W-1:0]  w_mask;
    logic signed [CALC_W-1:0]  w_delta;
    logic signed [CALC_W-1:0]  w_pred;
    logic signed [CALC_W-1:0]  w_sum_p;
    logic signed [CALC_W-1:0]  w_sum_n;

    always_comb begin
        w_r      = (i_range > RANGE_W'(MV_MAX_R)) ? RANGE_W'(MV_MAX_R) : i_range;
        w_lim    = CALC_W'(MV_BASE_RANGE) << w_r;
        w_mag    = i_code[CODE_W-1] ? CODE_W'(-i_code) : CODE_W'(i_code);
        w_mag_m1 = w_mag - CODE_W'(1);
        w_mask   = (CALC_W'(1) << w_r) - CALC_W'(1);
        w_delta  = signed'((CALC_W'(w_mag_m1) << w_r)
                   + (CALC_W'(i_resid) & w_mask) + CALC_W'(1));
        w_pred   = CALC_W'(i_pred);
        w_sum_p  = w_pred + w_delta;
        w_sum_n  = w_pred - w_delta;

        if (i_code == '0) begin
            o_result = w_pred;
        end else if (!i_code[CODE_W-1]) begin
            o_result = (w_sum_p >= w_lim) ? (w_sum_p - (w_lim <<< 1)) : w_sum_p;
        end else begin
            o_result = (w_sum_n < -w_lim) ? (w_sum_n + (w_lim <<< 1)) : w_sum_n;
        end
    end

endmodule

>>> rtl/mvr_pred_store.sv
// Predictor registers: four rows of horizontal and vertical predictors.
module mvr_pred_store import mvr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [ROW_W-1:0]         i_rd_row,
    input  t_pred_wr                 i_wr,
    output logic signed [PRED_W-1:0] o_pred_h,
    output logic signed [PRED_W-1:0] o_pred_v
);

    localparam int ROWS = 1 << ROW_W;

    logic signed [PRED_W-1:0] r_pred_h [ROWS];
    logic signed [PRED_W-1:0] r_pred_v [ROWS];
    logic        [ROW_W-1:0]  w_wr_row;
    logic        [ROW_W-1:0]  w_copy_row;

    assign w_wr_row   = {i_wr.dir, i_wr.share ? 1'b0 : i_wr.slot};
    assign w_copy_row = {i_wr.dir, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clear) begin
            for (int i = 0; i < ROWS; i++) begin
                r_pred_h[i] <= '0;
                r_pred_v[i] <= '0;
            end
        end else if (i_wr.we) begin
            r_pred_h[w_wr_row] <= i_wr.h;
            r_pred_v[w_wr_row] <= i_wr.v;
            if (i_wr.share) begin
                r_pred_h[w_copy_row] <= i_wr.h;
                r_pred_v[w_copy_row] <= i_wr.v;
            end
        end
    end

    assign o_pred_h = r_pred_h[i_rd_row];
    assign o_pred_v = r_pred_v[i_rd_row];

endmodule

>>> rtl/motion_vector_reconstruction_top.sv
// Top level of the motion vector reconstruction block.
// Each request passes through the input register and then the result register.
// Throughput: one vector per cycle while the output is not stalled; predictors update as the
// item leaves the input register, so the next item already sees the new value.
// Reset (i_rst_n low, synchronous): both stages empty, range registers and all
// predictors zero.
module motion_vector_reconstruction_top import mvr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [RANGE_W-1:0]        i_cfg_data,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_req_type,
    input  logic                      i_direction,
    input  logic                      i_slot,
    input  logic                      i_share_slots,
    input  logic                      i_field_scale,
    input  logic signed [CODE_W-1:0]  i_h_motion_code,
    input  logic        [RESID_W-1:0] i_h_motion_residual,
    input  logic signed [CODE_W-1:0]  i_v_motion_code,
    input  logic        [RESID_W-1:0] i_v_motion_residual,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [MVH_W-1:0]   o_mv_horizontal,
    output logic signed [MVV_W-1:0]   o_mv_vertical
);

    // Residual size registers
    logic [RANGE_W-1:0] r_fwd_h_range;
    logic [RANGE_W-1:0] r_fwd_v_range;
    logic [RANGE_W-1:0] r_bwd_h_range;
    logic [RANGE_W-1:0] r_bwd_v_range;

    // Input register
    logic                      r_in_vld;
    logic                      r_in_req;
    logic                      r_in_dir;
    logic                      r_in_slot;
    logic                      r_in_share;
    logic                      r_in_fscale;
    logic signed [CODE_W-1:0]  r_in_h_code;
    logic        [RESID_W-1:0] r_in_h_resid;
    logic signed [CODE_W-1:0]  r_in_v_code;
    logic        [RESID_W-1:0] r_in_v_resid;

    // Result register
    logic                      r_out_vld;
    logic signed [MVH_W-1:0]   r_mv_h;
    logic signed [MVV_W-1:0]   r_mv_v;

    logic                      w_in_xfer;
    logic                      w_adv;
    logic [ROW_W-1:0]          w_rd_row;
    logic signed [PRED_W-1:0]  w_pred_h;
    logic signed [PRED_W-1:0]  w_pred_v;
    logic signed [PRED_W-1:0]  w_pred_v_sc;
    logic [RANGE_W-1:0]        w_h_range;
    logic [RANGE_W-1:0]        w_v_range;
    logic signed [CALC_W-1:0]  w_h_calc;
    logic signed [CALC_W-1:0]  w_v_calc;
    logic signed [PRED_W-1:0]  w_h_new;
    logic signed [PRED_W-1:0]  w_v_new;
    t_pred_wr                  w_pred_wr;

    // The item in the input register moves on whenever the result register is
    // empty or its content is taken in this cycle.
    assign w_adv      = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_adv;
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    // Configuration writes; the block is to be idle when these arrive (the user's rule, not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_h_range <= '0;
            r_fwd_v_range <= '0;
            r_bwd_h_range <= '0;
            r_bwd_v_range <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FWD_H: r_fwd_h_range <= i_cfg_data;
                CFG_FWD_V: r_fwd_v_range <= i_cfg_data;
                CFG_BWD_H: r_bwd_h_range <= i_cfg_data;
                CFG_BWD_V: r_bwd_v_range <= i_cfg_data;
                default:   r_fwd_h_range <= r_fwd_h_range;
            endcase
        end
    end

    // Input register: valid bit under reset, payload loads on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_req     <= i_req_type;
            r_in_dir     <= i_direction;
            r_in_slot    <= i_slot;
            r_in_share   <= i_share_slots;
            r_in_fscale  <= i_field_scale;
            r_in_h_code  <= i_h_motion_code;
            r_in_h_resid <= i_h_motion_residual;
            r_in_v_code  <= i_v_motion_code;
            r_in_v_resid <= i_v_motion_residual;
        end
    end

    // A single-vector request always works on slot 0.
    assign w_rd_row  = {r_in_dir, r_in_share ? 1'b0 : r_in_slot};
    assign w_h_range = r_in_dir ? r_bwd_h_range : r_fwd_h_range;
    assign w_v_range = r_in_dir ? r_bwd_v_range : r_fwd_v_range;

    mvr_pred_store u_pred_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_row (w_rd_row),
        .i_wr     (w_pred_wr),
        .o_pred_h (w_pred_h),
        .o_pred_v (w_pred_v)
    );

    // Field scaling halves the vertical predictor (floor) before the update.
    assign w_pred_v_sc = r_in_fscale ? (w_pred_v >>> 1) : w_pred_v;

    mvr_rebuild u_rebuild_h (
        .i_pred   (w_pred_h),
        .i_range  (w_h_range),
        .i_code   (r_in_h_code),
        .i_resid  (r_in_h_resid),
        .o_result (w_h_calc)
    );

    mvr_rebuild u_rebuild_v (
        .i_pred   (w_pred_v_sc),
        .i_range  (w_v_range),
        .i_code   (r_in_v_code),
        .i_resid  (r_in_v_resid),
        .o_result (w_v_calc)
    );

    // Keep 14-bit two's complement; doubling drops the top bit and shifts in zero.
    assign w_h_new = w_h_calc[PRED_W-1:0];
    assign w_v_new = r_in_fscale ? {w_v_calc[PRED_W-2:0], 1'b0} : w_v_calc[PRED_W-1:0];

    always_comb begin
        w_pred_wr.clear = w_adv && (r_in_req == REQ_RESET);
        w_pred_wr.we    = w_adv && (r_in_req == REQ_DECODE);
        w_pred_wr.dir   = r_in_dir;
        w_pred_wr.slot  = r_in_slot;
        w_pred_wr.share = r_in_share;
        w_pred_wr.h     = w_h_new;
        w_pred_wr.v     = w_v_new;
    end

    // Result register: hold while stalled, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_in_req == REQ_RESET) begin
                r_mv_h <= '0;
                r_mv_v <= '0;
            end else begin
                r_mv_h <= w_h_new[MVH_W-1:0];
                r_mv_v <= w_v_new[MVV_W-1:0];
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_mv_horizontal = r_mv_h;
    assign o_mv_vertical   = r_mv_v;

endmodule

>>> rtl/mvr_checker.sv
// Port-level checks for the motion vector reconstruction top level, with bind.
module mvr_checker import mvr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      o_in_stall,
    input  logic                      o_out_valid,
    input  logic                      i_out_stall,
    input  logic signed [MVH_W-1:0]   o_mv_horizontal,
    input  logic signed [MVV_W-1:0]   o_mv_vertical
);

    // Reset empties both stages.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not empty after reset");

    // Input stalls only while a result is held back at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_mv_horizontal) && $stable(o_mv_vertical)))
        else $error("stalled result changed");

    // With the output free, the input never stalls.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || !i_out_stall) |-> !o_in_stall)
        else $error("input stalled with output free");

endmodule

bind motion_vector_reconstruction_top mvr_checker u_mvr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_mv_horizontal (o_mv_horizontal),
    .o_mv_vertical   (o_mv_vertical)
);
